FILE: sv/i2c_master_bit_engine_unit_defines.svh
// Assertion macros for the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define I2CM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define I2CM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CntW = 16;
    localparam int RecoveryPulses = 9;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_HALF = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TMO = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WLOW = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_WHIGH = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NACK = 2'd1;
    localparam logic [1:0] ST_TMO = 2'd2;
    localparam logic [1:0] ST_LINE = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ = 3'd4,
        CMD_RECOVER = 3'd5,
        CMD_WAKE = 3'd6,
        CMD_RSVD = 3'd7
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_WAIT, PH_ST_D1, PH_ST_D2,
        PH_SP_D1, PH_SP_WAIT, PH_SP_D2, PH_SP_D3,
        PH_WR_D1, PH_WR_WAIT, PH_WR_D2,
        PH_RD_D1, PH_RD_WAIT, PH_RD_D2,
        PH_RC_WAIT, PH_RC_D1, PH_RC_WAIT2, PH_RC_D2,
        PH_WK_WAIT, PH_WK_D1, PH_WK_LOW, PH_WK_HIGH
    } t_phase;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       scl_in;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
    } t_out;

endpackage

FILE: sv/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// Open-drain I2C master bit engine, one timebase tick per beat.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | i_in_valid/o_in_ready | i_in  (i2cm_pkg::t_in)
//  out     | o_out_valid/i_out_ready | o_out (i2cm_pkg::t_out)
//  cfg     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One beat per cycle while the output is not stalled: the sequencer updates
// in the cycle a tick beat is taken and the result sits in an output register in the cycle after.
// A tick is taken whenever the output register is empty or being drained,
// so a stalled output stops the sequencer with it.
// Reset (sync, active low) returns phase, counters, drives and config.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  i2cm_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output i2cm_pkg::t_out                o_out,
    input  logic                          i_cfg_we,
    input  logic [i2cm_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [i2cm_pkg::CfgDataW-1:0] i_cfg_data
);
    localparam int CW = i2cm_pkg::CntW;

    // config registers
    logic [CW-1:0] r_half, r_tmo, r_wlow, r_whigh;

    // sequencer state
    i2cm_pkg::t_phase r_phase, n_phase;
    logic [3:0]    r_bits, n_bits;
    logic [7:0]    r_shift, n_shift;
    logic [CW-1:0] r_dly, n_dly;
    logic [CW-1:0] r_str, n_str;
    logic          r_scl, n_scl, r_sda, n_sda, r_ack, n_ack;
    logic [1:0]    r_st, n_st;
    logic [7:0]    r_rx, n_rx;
    logic          n_done;

    // output register
    logic           r_ovalid;
    i2cm_pkg::t_out r_out;

    logic take;
    assign o_in_ready  = !r_ovalid || i_out_ready;
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= CW'(5);
            r_tmo   <= CW'(1000);
            r_wlow  <= CW'(80);
            r_whigh <= CW'(2500);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2cm_pkg::CFG_HALF:  r_half  <= i_cfg_data;
                i2cm_pkg::CFG_TMO:   r_tmo   <= i_cfg_data;
                i2cm_pkg::CFG_WLOW:  r_wlow  <= i_cfg_data;
                i2cm_pkg::CFG_WHIGH: r_whigh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // delay expires when count is 0 or 1; stretch times out on count+1 >= tmo
    logic dly_end, scl_hi, tmo_hit;
    assign dly_end = (r_dly <= CW'(1));
    assign scl_hi  = i_in.scl_in;
    assign tmo_hit = ({1'b0, r_str} + (CW+1)'(1)) >= {1'b0, r_tmo};

    always_comb begin
        n_phase = r_phase; n_bits = r_bits; n_shift = r_shift;
        n_dly = r_dly; n_str = r_str; n_scl = r_scl; n_sda = r_sda;
        n_ack = r_ack; n_st = r_st; n_rx = r_rx; n_done = 1'b0;
        if (!dly_end) n_dly = r_dly - CW'(1);
        if (!scl_hi && !tmo_hit) n_str = r_str + CW'(1);
        unique case (r_phase)
            i2cm_pkg::PH_IDLE: begin
                n_dly = r_dly; n_str = r_str;
                unique case (i2cm_pkg::t_cmd'(i_in.cmd))
                    i2cm_pkg::CMD_START: begin
                        n_sda = 1'b0; n_scl = 1'b0; n_str = '0;
                        n_phase = i2cm_pkg::PH_ST_WAIT;
                    end
                    i2cm_pkg::CMD_STOP: begin
                        n_ack = 1'b0; n_sda = 1'b1; n_dly = r_half;
                        n_phase = i2cm_pkg::PH_SP_D1;
                    end
                    i2cm_pkg::CMD_WRITE: begin
                        n_shift = i_in.tx_byte; n_bits = '0; n_ack = 1'b0;
                        n_sda = !i_in.tx_byte[7]; n_dly = r_half;
                        n_phase = i2cm_pkg::PH_WR_D1;
                    end
                    i2cm_pkg::CMD_READ: begin
                        n_sda = 1'b0; n_shift = '0; n_bits = '0;
                        n_ack = i_in.ack_after_read; n_dly = r_half;
                        n_phase = i2cm_pkg::PH_RD_D1;
                    end
                    i2cm_pkg::CMD_RECOVER: begin
                        n_sda = 1'b0; n_ack = 1'b1; n_bits = '0;
                        n_scl = 1'b0; n_str = '0;
                        n_phase = i2cm_pkg::PH_RC_WAIT;
                    end
                    i2cm_pkg::CMD_WAKE: begin
                        n_sda = 1'b0; n_scl = 1'b0; n_str = '0;
                        n_phase = i2cm_pkg::PH_WK_WAIT;
                    end
                    default: ;
                endcase
            end
            i2cm_pkg::PH_ST_WAIT, i2cm_pkg::PH_RC_WAIT2, i2cm_pkg::PH_WK_WAIT: begin
                if (scl_hi) begin
                    n_dly = r_half;
                    n_phase = (r_phase == i2cm_pkg::PH_ST_WAIT) ? i2cm_pkg::PH_ST_D1 :
                              (r_phase == i2cm_pkg::PH_RC_WAIT2) ? i2cm_pkg::PH_RC_D2 :
                              i2cm_pkg::PH_WK_D1;
                end else if (tmo_hit) begin
                    n_st = i2cm_pkg::ST_TMO; n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_ST_D1, i2cm_pkg::PH_WK_D1: if (dly_end) begin
                if (!i_in.sda_in) begin
                    n_st = i2cm_pkg::ST_LINE; n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
                end else begin
                    n_sda = 1'b1;
                    if (r_phase == i2cm_pkg::PH_ST_D1) begin
                        n_dly = r_half; n_phase = i2cm_pkg::PH_ST_D2;
                    end else begin
                        n_dly = r_wlow; n_phase = i2cm_pkg::PH_WK_LOW;
                    end
                end
            end
            i2cm_pkg::PH_ST_D2: if (dly_end) begin
                n_scl = 1'b1; n_st = i2cm_pkg::ST_OK; n_done = 1'b1;
                n_phase = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::PH_SP_D1, i2cm_pkg::PH_WR_D1, i2cm_pkg::PH_RD_D1,
            i2cm_pkg::PH_RC_D1: if (dly_end) begin
                n_scl = 1'b0; n_str = '0;
                n_phase = (r_phase == i2cm_pkg::PH_SP_D1) ? i2cm_pkg::PH_SP_WAIT :
                          (r_phase == i2cm_pkg::PH_WR_D1) ? i2cm_pkg::PH_WR_WAIT :
                          (r_phase == i2cm_pkg::PH_RD_D1) ? i2cm_pkg::PH_RD_WAIT :
                          i2cm_pkg::PH_RC_WAIT2;
            end
            i2cm_pkg::PH_SP_WAIT: begin
                if (scl_hi) begin
                    n_dly = r_half; n_phase = i2cm_pkg::PH_SP_D2;
                end else if (tmo_hit) begin
                    n_sda = 1'b0; n_st = i2cm_pkg::ST_TMO; n_done = 1'b1;
                    n_phase = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_SP_D2: if (dly_end) begin
                n_sda = 1'b0; n_dly = r_half; n_phase = i2cm_pkg::PH_SP_D3;
            end
            i2cm_pkg::PH_SP_D3: if (dly_end) begin
                n_st = (i_in.sda_in && (!r_ack || scl_hi)) ? i2cm_pkg::ST_OK
                                                            : i2cm_pkg::ST_LINE;
                n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::PH_WR_WAIT: begin
                if (scl_hi) begin
                    if (r_bits[3]) n_ack = i_in.sda_in;
                    n_dly = r_half; n_phase = i2cm_pkg::PH_WR_D2;
                end else if (tmo_hit) begin
                    n_st = i2cm_pkg::ST_TMO; n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_WR_D2: if (dly_end) begin
                n_scl = 1'b1;
                if (r_bits[3]) begin
                    n_st = r_ack ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
                    n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
                end else begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bits = r_bits + 4'd1;
                    n_sda = (r_bits != 4'd7) && !r_shift[6];
                    n_dly = r_half; n_phase = i2cm_pkg::PH_WR_D1;
                end
            end
            i2cm_pkg::PH_RD_WAIT: begin
                if (scl_hi) begin
                    if (!r_bits[3]) n_shift = {r_shift[6:0], i_in.sda_in};
                    n_dly = r_half; n_phase = i2cm_pkg::PH_RD_D2;
                end else if (tmo_hit) begin
                    n_st = i2cm_pkg::ST_TMO; n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_RD_D2: if (dly_end) begin
                n_scl = 1'b1;
                if (r_bits[3]) begin
                    n_sda = 1'b0; n_rx = r_shift; n_st = i2cm_pkg::ST_OK;
                    n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
                end else begin
                    n_bits = r_bits + 4'd1;
                    if (r_bits == 4'd7) n_sda = r_ack;
                    n_dly = r_half; n_phase = i2cm_pkg::PH_RD_D1;
                end
            end
            i2cm_pkg::PH_RC_WAIT: begin
                if (scl_hi) begin
                    n_dly = r_half;
                    if (i_in.sda_in) begin
                        n_sda = 1'b1; n_phase = i2cm_pkg::PH_SP_D1;
                    end else begin
                        n_scl = 1'b1; n_phase = i2cm_pkg::PH_RC_D1;
                    end
                end else if (tmo_hit) begin
                    n_st = i2cm_pkg::ST_TMO; n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_RC_D2: if (dly_end) begin
                n_dly = r_half;
                if (i_in.sda_in || ({1'b0, r_bits} + 5'd1 >=
                                    5'(i2cm_pkg::RecoveryPulses))) begin
                    n_sda = 1'b1; n_phase = i2cm_pkg::PH_SP_D1;
                end else begin
                    n_bits = r_bits + 4'd1; n_scl = 1'b1;
                    n_phase = i2cm_pkg::PH_RC_D1;
                end
            end
            i2cm_pkg::PH_WK_LOW: if (dly_end) begin
                n_sda = 1'b0; n_dly = r_whigh; n_phase = i2cm_pkg::PH_WK_HIGH;
            end
            i2cm_pkg::PH_WK_HIGH: if (dly_end) begin
                n_st = (i_in.sda_in && scl_hi) ? i2cm_pkg::ST_OK : i2cm_pkg::ST_LINE;
                n_done = 1'b1; n_phase = i2cm_pkg::PH_IDLE;
            end
            default: n_phase = i2cm_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cm_pkg::PH_IDLE;
            r_bits <= '0; r_shift <= '0; r_dly <= '0; r_str <= '0;
            r_scl <= 1'b0; r_sda <= 1'b0; r_ack <= 1'b0; r_st <= '0; r_rx <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_bits <= n_bits; r_shift <= n_shift;
                r_dly <= n_dly; r_str <= n_str; r_scl <= n_scl; r_sda <= n_sda;
                r_ack <= n_ack; r_st <= n_st; r_rx <= n_rx;
            end
            if (o_in_ready) r_ovalid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.scl_drive_low <= n_scl;
            r_out.sda_drive_low <= n_sda;
            r_out.busy_res      <= (n_phase != i2cm_pkg::PH_IDLE);
            r_out.done_res      <= n_done;
            r_out.status        <= n_st;
            r_out.rx_byte       <= n_rx;
        end
    end
endmodule

FILE: sv/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master bit engine.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_unit_defines.svh"
module i2cm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input i2cm_pkg::t_out o_out
);
    `I2CM_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "not ready while empty")
    `I2CM_ASSERT_NXT(a_beat_makes_out, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid, "beat lost")
    `I2CM_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_out.done_res, !o_out.busy_res, "done while busy")
    `I2CM_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "output changed under stall")
endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out(o_out)
);
